// File: rtl/tick_keypad_and_sensor_sequencer_unit_macros.svh
// assertion macros for the tick keypad and sensor sequencer unit
// used by the checker module; no other dependencies
`ifndef TICK_KEYPAD_AND_SENSOR_SEQUENCER_UNIT_MACROS_SVH
`define TICK_KEYPAD_AND_SENSOR_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TKSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkss assertion failed");

// next-cycle implication, disabled during reset
`define TKSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkss assertion failed");

`endif

// File: rtl/tkss_pkg.sv
// shared types, constants and packing for the tick keypad and sensor sequencer
// no dependencies
package tkss_pkg;

  localparam int PRESCALE_WRAP_DEF  = 1024;
  localparam int SHORT_PRESS_TICKS  = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // ops
  localparam logic [2:0] OP_TICK         = 3'd0;
  localparam logic [2:0] OP_LOAD_SD      = 3'd1;
  localparam logic [2:0] OP_LOAD_WRITE   = 3'd2;
  localparam logic [2:0] OP_LOAD_GEN     = 3'd3;
  localparam logic [2:0] OP_CLR_SYSTICK  = 3'd4;

  // register indexes
  localparam logic REG_PRESSURE_EN = 1'b0;

  // key codes and debounce constants
  localparam logic [1:0] KEY_NONE           = 2'd3;
  localparam logic [3:0] LONG_PRESS_TICKS   = 4'd15;
  localparam logic [3:0] LONG_REPEAT_RELOAD = 4'd13;

  // periods, minus one
  localparam logic [7:0] PERIOD_IDLE    = 8'd49;
  localparam logic [7:0] PERIOD_NO_PRES = 8'd39;
  localparam logic [7:0] PERIOD_STEP    = 8'd19;
  localparam logic [7:0] PERIOD_MES     = 8'd9;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] load_value;
    logic [2:0]  key_pins;
    logic        measure_enable;
  } tkss_item_t;

  typedef struct packed {
    logic        key_event;
    logic        key_long;
    logic [1:0]  key_id;
    logic        second_tick;
    logic        heater_on;
    logic        pressure_on;
    logic        temp_sensor_on;
    logic        adc_start;
    logic [7:0]  next_period;
    logic [15:0] sd_remaining;
    logic [15:0] write_remaining;
    logic [15:0] gen_remaining;
  } tkss_result_t;

  function automatic tkss_item_t unpack_item(input logic [IN_TUSER_W-1:0] user,
                                             input logic [IN_TDATA_W-1:0] data);
    tkss_item_t it;
    it.op             = user;
    it.load_value     = data[15:0];
    it.key_pins       = data[18:16];
    it.measure_enable = data[19];
    return it;
  endfunction

  function automatic logic [OUT_TDATA_W-1:0] pack_result(input tkss_result_t r);
    return {7'd0, r.gen_remaining, r.write_remaining, r.sd_remaining, r.next_period,
            r.adc_start, r.temp_sensor_on, r.pressure_on, r.heater_on, r.second_tick,
            r.key_id, r.key_long, r.key_event};
  endfunction

endpackage

// File: rtl/tkss_cfg.sv
// apb-style configuration register block
// depends on tkss_pkg
module tkss_cfg
  import tkss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic                  pressure_enabled
);

  logic pressure_en_r;
  logic pressure_en_nxt;
  logic sel_pe;

  assign sel_pe     = (cfg_paddr[CFG_ADDR_W-1:2] == REG_PRESSURE_EN);
  assign cfg_pready = 1'b1;

  always_comb begin
    pressure_en_nxt = pressure_en_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_pe) begin
      pressure_en_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressure_en_r <= 1'b0;
    end else begin
      pressure_en_r <= pressure_en_nxt;
    end
  end

  assign cfg_prdata       = sel_pe ? {{(CFG_DATA_W-1){1'b0}}, pressure_en_r} : '0;
  assign pressure_enabled = pressure_en_r;

endmodule

// File: rtl/tkss_core.sv
// state registers and single-pass update for timers, prescaler, keys and sequencer
// depends on tkss_pkg
module tkss_core
  import tkss_pkg::*;
#(
  parameter int PRESCALE_WRAP = PRESCALE_WRAP_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  tkss_item_t   item,
  input  logic         pressure_enabled,
  output tkss_result_t result
);

  localparam int PW = $clog2(PRESCALE_WRAP) + 1;

  typedef enum logic [3:0] {
    SEQ_WAIT = 4'b0001,
    SEQ_PRES = 4'b0010,
    SEQ_RES  = 4'b0100,
    SEQ_MES  = 4'b1000
  } seq_state_t;

  logic [15:0]   sd_r, sd_nxt;
  logic [15:0]   wr_r, wr_nxt;
  logic [15:0]   gen_r, gen_nxt;
  logic [PW-1:0] presc_r, presc_nxt;
  logic          systick_r, systick_nxt;
  logic [7:0]    period_r, period_nxt;
  logic [3:0]    hold_r, hold_nxt;
  logic [1:0]    prev_key_r, prev_key_nxt;
  seq_state_t    seq_r, seq_nxt;

  logic [8:0]    step;
  logic [PW-1:0] presc_sum;
  logic [2:0]    pressed;
  logic [1:0]    key;
  logic [3:0]    hold_inc;

  assign step      = {1'b0, period_r} + 9'd1;
  assign presc_sum = presc_r + PW'(step);
  assign pressed   = ~item.key_pins;

  always_comb begin
    unique case (pressed)
      3'b001:  key = 2'd0;
      3'b010:  key = 2'd1;
      3'b100:  key = 2'd2;
      default: key = KEY_NONE;
    endcase
  end

  always_comb begin
    if (key == KEY_NONE) begin
      hold_inc = 4'd0;
    end else if (key == prev_key_r) begin
      hold_inc = hold_r + 4'd1;
    end else begin
      hold_inc = 4'd0;
    end
  end

  always_comb begin
    sd_nxt       = sd_r;
    wr_nxt       = wr_r;
    gen_nxt      = gen_r;
    presc_nxt    = presc_r;
    systick_nxt  = systick_r;
    period_nxt   = period_r;
    hold_nxt     = hold_r;
    prev_key_nxt = prev_key_r;
    seq_nxt      = seq_r;
    result       = '0;

    unique case (item.op)
      OP_TICK: begin
        sd_nxt = ({7'd0, step} < sd_r) ? (sd_r - {7'd0, step}) : 16'd0;

        if (presc_sum >= PW'(PRESCALE_WRAP)) begin
          presc_nxt          = presc_sum - PW'(PRESCALE_WRAP);
          wr_nxt             = (wr_r != 16'd0) ? (wr_r - 16'd1) : 16'd0;
          gen_nxt            = (gen_r != 16'd0) ? (gen_r - 16'd1) : 16'd0;
          systick_nxt        = 1'b1;
          result.second_tick = 1'b1;
        end else begin
          presc_nxt = presc_sum;
        end

        prev_key_nxt = key;
        hold_nxt     = hold_inc;
        if (hold_inc == LONG_PRESS_TICKS) begin
          result.key_event = 1'b1;
          result.key_long  = 1'b1;
          result.key_id    = key;
          hold_nxt         = LONG_REPEAT_RELOAD;
        end else if (hold_inc == 4'(SHORT_PRESS_TICKS)) begin
          result.key_event = 1'b1;
          result.key_id    = key;
        end

        unique case (seq_r)
          SEQ_WAIT: begin
            if (systick_nxt && item.measure_enable) begin
              result.heater_on = 1'b1;
              if (pressure_enabled) begin
                period_nxt = PERIOD_STEP;
                seq_nxt    = SEQ_PRES;
              end else begin
                period_nxt = PERIOD_NO_PRES;
                seq_nxt    = SEQ_RES;
              end
            end else begin
              period_nxt = PERIOD_IDLE;
            end
          end
          SEQ_PRES: begin
            result.pressure_on = 1'b1;
            seq_nxt            = SEQ_RES;
            period_nxt         = PERIOD_STEP;
          end
          SEQ_RES: begin
            result.temp_sensor_on = 1'b1;
            seq_nxt               = SEQ_MES;
            period_nxt            = PERIOD_MES;
          end
          SEQ_MES: begin
            result.adc_start = 1'b1;
            seq_nxt          = SEQ_WAIT;
            period_nxt       = PERIOD_IDLE;
          end
          default: begin
            seq_nxt    = SEQ_WAIT;
            period_nxt = PERIOD_IDLE;
          end
        endcase
      end
      OP_LOAD_SD:     sd_nxt      = item.load_value;
      OP_LOAD_WRITE:  wr_nxt      = item.load_value;
      OP_LOAD_GEN:    gen_nxt     = item.load_value;
      OP_CLR_SYSTICK: systick_nxt = 1'b0;
      default: begin
      end
    endcase

    result.next_period     = period_nxt;
    result.sd_remaining    = sd_nxt;
    result.write_remaining = wr_nxt;
    result.gen_remaining   = gen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r       <= '0;
      wr_r       <= '0;
      gen_r      <= '0;
      presc_r    <= '0;
      systick_r  <= 1'b0;
      period_r   <= PERIOD_IDLE;
      hold_r     <= '0;
      prev_key_r <= KEY_NONE;
      seq_r      <= SEQ_WAIT;
    end else if (advance) begin
      sd_r       <= sd_nxt;
      wr_r       <= wr_nxt;
      gen_r      <= gen_nxt;
      presc_r    <= presc_nxt;
      systick_r  <= systick_nxt;
      period_r   <= period_nxt;
      hold_r     <= hold_nxt;
      prev_key_r <= prev_key_nxt;
      seq_r      <= seq_nxt;
    end
  end

endmodule

// File: rtl/tick_keypad_and_sensor_sequencer_unit.sv
// top level of the tick keypad and sensor sequencer: input register, core, result register
// depends on tkss_pkg, tkss_cfg and tkss_core
//
// channel  | direction | handshake            | contents
// in_      | in        | tvalid/tready        | tuser op, tdata load_value/key_pins/measure_enable
// out_     | out       | tvalid/tready        | tdata key, pulse, period and countdown fields
// cfg_     | in        | apb psel/penable     | pressure_enabled at byte address 0
//
// one transaction per cycle sustained while out_tready is high; each item is registered
// in the input register and processed as it moves from there to the result register
// reset is synchronous, active low; clears valid flags and core state, not data registers; no clearing pass
// a stall on out_tready holds the result and fills the input register, then drops in_tready
module tick_keypad_and_sensor_sequencer_unit
  import tkss_pkg::*;
#(
  parameter int PRESCALE_WRAP = PRESCALE_WRAP_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // load_value, key_pins, measure_enable, pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // key_event, key_long, key_id, second_tick,
                                             // heater_on, pressure_on, temp_sensor_on,
                                             // adc_start, next_period, sd_remaining,
                                             // write_remaining, gen_remaining, pad
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  logic                   in_v_r;
  tkss_item_t             in_item_r;
  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   advance;
  logic                   pressure_enabled;
  tkss_result_t           result;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  tkss_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .pressure_enabled (pressure_enabled)
  );

  tkss_core #(
    .PRESCALE_WRAP (PRESCALE_WRAP)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .item             (in_item_r),
    .pressure_enabled (pressure_enabled),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= unpack_item(in_tuser, in_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= pack_result(result);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/tkss_checker.sv
// port-level checker for the tick keypad and sensor sequencer, bound to the top level
// depends on tkss_pkg and the macro header
`include "tick_keypad_and_sensor_sequencer_unit_macros.svh"

module tkss_checker
  import tkss_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // stalled result stays put
  `TKSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // with no result waiting the input side is always open
  `TKSS_ASSERT_NOW(a_in_open, clk, rst_n, !out_tvalid, in_tready)

  // a long press is always a reported press of a real key
  `TKSS_ASSERT_NOW(a_long_key, clk, rst_n, out_tvalid && out_tdata[1], out_tdata[0] && (out_tdata[3:2] != KEY_NONE))

  // the sequencer fires at most one supply pulse per result
  `TKSS_ASSERT_NOW(a_one_pulse, clk, rst_n, out_tvalid, $onehot0(out_tdata[8:5]))

endmodule

bind tick_keypad_and_sensor_sequencer_unit tkss_checker u_tkss_checker (.*);
